>>> hdl/ptd_pkg.sv
package ptd_pkg;

  localparam int MaxTasks = 16;
  localparam int SlotW = $clog2(MaxTasks);
  localparam int CountW = $clog2(MaxTasks + 1);

  localparam logic [1:0] FuncAdd = 2'd0;
  localparam logic [1:0] FuncTick = 2'd1;
  localparam logic [1:0] FuncDispatch = 2'd2;
  localparam logic [1:0] FuncDelete = 2'd3;

  localparam logic [1:0] KindRun = 2'd0;
  localparam logic [1:0] KindAdded = 2'd1;
  localparam logic [1:0] KindFull = 2'd2;

  localparam logic [1:0] RegTickLength = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TICK,
    ST_DISP,
    ST_EMIT,
    ST_DEL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic add_write;
    logic tick_step;
    logic disp_step;
    logic remove;
    logic idx_clear;
    logic idx_inc;
    logic emit_run;
    logic emit_add;
    logic emit_full;
  } ptd_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic div_done;
    logic full;
    logic idx_end;
    logic hit;
    logic one_shot;
    logic more_hits;
  } ptd_stat_t;

endpackage

>>> hdl/ptd_divider.sv
module ptd_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend_a,
  input  logic [31:0] dividend_b,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quot_a,
  output logic [31:0] quot_b
);
  import ptd_pkg::*;

  logic [5:0]  count;
  logic        busy;
  logic [15:0] dv;
  logic [16:0] rem_a;
  logic [16:0] rem_b;
  logic [16:0] tr_a;
  logic [16:0] tr_b;

  // One quotient bit of each operand per cycle, restoring form.
  assign tr_a = {rem_a[15:0], quot_a[31]};
  assign tr_b = {rem_b[15:0], quot_b[31]};
  assign done = busy && (count == 6'd32);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      count <= count + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_a <= dividend_a;
      quot_b <= dividend_b;
      rem_a <= '0;
      rem_b <= '0;
      dv <= (divisor == 16'd0) ? 16'd1 : divisor;
    end else if (busy && !done) begin
      if (tr_a >= {1'b0, dv}) begin
        rem_a <= tr_a - {1'b0, dv};
        quot_a <= {quot_a[30:0], 1'b1};
      end else begin
        rem_a <= tr_a;
        quot_a <= {quot_a[30:0], 1'b0};
      end
      if (tr_b >= {1'b0, dv}) begin
        rem_b <= tr_b - {1'b0, dv};
        quot_b <= {quot_b[30:0], 1'b1};
      end else begin
        rem_b <= tr_b;
        quot_b <= {quot_b[30:0], 1'b0};
      end
    end
  end
endmodule

>>> hdl/ptd_datapath.sv
module ptd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ptd_pkg::ptd_cmd_t   cmd,
  output ptd_pkg::ptd_stat_t  stat,
  input  logic [15:0]         tick_length,
  input  logic [1:0]          func_in,
  input  logic [7:0]          tag_in,
  input  logic [31:0]         delay_in,
  input  logic [31:0]         period_in,
  input  logic [3:0]          slot_in,
  output logic [1:0]          func_q,
  output logic [1:0]          res_kind,
  output logic [7:0]          res_tag,
  output logic [3:0]          res_slot
);
  import ptd_pkg::*;

  logic [7:0]        tags [MaxTasks];
  logic [31:0]       delays [MaxTasks];
  logic [31:0]       periods [MaxTasks];
  logic [7:0]        pend [MaxTasks];
  logic [CountW-1:0] task_count;
  logic [CountW-1:0] idx;
  logic [7:0]        tag_q;
  logic [3:0]        slot_q;
  logic              div_done;
  logic [31:0]       q_delay;
  logic [31:0]       q_period;
  logic [SlotW-1:0]  cur;
  logic [SlotW-1:0]  last_i;
  logic [SlotW-1:0]  rm_i;
  logic              rm_ok;
  logic [CountW-1:0] rm_wide;
  logic [CountW-1:0] hit_lim;
  logic [MaxTasks-1:0] hit_vec;

  assign cur = idx[SlotW-1:0];
  assign last_i = SlotW'(task_count - CountW'(1));

  ptd_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend_a(delay_in), .dividend_b(period_in), .divisor(tick_length),
    .done(div_done), .quot_a(q_delay), .quot_b(q_period)
  );

  // A one-shot slot is removed when it runs, so the last entry moves into it and is skipped.
  assign hit_lim = (periods[cur] == 32'd0) ? (task_count - CountW'(1)) : task_count;

  // Pending flags of slots past the walk pointer.
  always_comb begin
    for (int k = 0; k < MaxTasks; k++) begin
      hit_vec[k] = (CountW'(k) > idx) && (CountW'(k) < hit_lim) && (pend[k] != 8'd0);
    end
  end

  assign stat.div_done = div_done;
  assign stat.full = (task_count == CountW'(MaxTasks));
  assign stat.idx_end = (idx >= task_count);
  assign stat.hit = (pend[cur] != 8'd0);
  assign stat.one_shot = (periods[cur] == 32'd0);
  assign stat.more_hits = |hit_vec;

  // Slot removal: walk slot during dispatch, input slot on delete.
  always_comb begin
    rm_wide = cmd.disp_step ? idx : CountW'(slot_q);
    rm_i = rm_wide[SlotW-1:0];
    rm_ok = (rm_wide < task_count);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func_in;
      tag_q <= tag_in;
      slot_q <= slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CountW'(1);
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (cmd.emit_run) begin
      res_kind <= KindRun;
      res_tag <= tags[cur];
      res_slot <= 4'(cur);
    end else if (cmd.emit_add) begin
      res_kind <= KindAdded;
      res_tag <= tag_q;
      res_slot <= 4'(task_count);
    end else if (cmd.emit_full) begin
      res_kind <= KindFull;
      res_tag <= tag_q;
      res_slot <= 4'd0;
    end
  end

  // Table update.
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      for (int k = 0; k < MaxTasks; k++) begin
        tags[k] <= '0;
        delays[k] <= '0;
        periods[k] <= '0;
        pend[k] <= '0;
      end
    end else if (cmd.add_write) begin
      tags[SlotW'(task_count)] <= tag_q;
      delays[SlotW'(task_count)] <= q_delay;
      periods[SlotW'(task_count)] <= q_period;
      pend[SlotW'(task_count)] <= '0;
      task_count <= task_count + CountW'(1);
    end else if (cmd.tick_step) begin
      if (delays[cur] != 32'd0) begin
        delays[cur] <= delays[cur] - 32'd1;
      end else begin
        delays[cur] <= periods[cur];
        if (pend[cur] != 8'd255) pend[cur] <= pend[cur] + 8'd1;
      end
    end else if (cmd.disp_step && !cmd.remove) begin
      pend[cur] <= pend[cur] - 8'd1;
    end else if (cmd.remove && rm_ok) begin
      if (rm_i != last_i) begin
        tags[rm_i] <= tags[last_i];
        delays[rm_i] <= delays[last_i];
        periods[rm_i] <= periods[last_i];
        pend[rm_i] <= pend[last_i];
      end
      tags[last_i] <= '0;
      delays[last_i] <= '0;
      periods[last_i] <= '0;
      pend[last_i] <= '0;
      task_count <= task_count - CountW'(1);
    end
  end
endmodule

>>> hdl/ptd_ctrl.sv
module ptd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_last,
  input  ptd_pkg::ptd_stat_t stat,
  output ptd_pkg::ptd_cmd_t  cmd
);
  import ptd_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_last_next;
  logic   in_fire;
  logic   free;
  logic   disp_emit;

  // The output register is free when empty or taken this cycle.
  assign free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign in_fire = in_valid && (state == ST_IDLE);
  assign disp_emit = (state == ST_DISP) && !stat.idx_end && stat.hit && free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (func_in)
            FuncAdd: state_next = ST_DIV;
            FuncTick: state_next = ST_TICK;
            FuncDispatch: state_next = ST_DISP;
            default: state_next = ST_DEL;
          endcase
        end
      end
      ST_DIV: if (stat.div_done) state_next = ST_EMIT;
      ST_EMIT: if (free) state_next = ST_IDLE;
      ST_TICK: if (stat.idx_end) state_next = ST_IDLE;
      ST_DISP: if (stat.idx_end) state_next = ST_IDLE;
      ST_DEL: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load = in_fire;
        cmd.div_start = in_fire && (func_in == FuncAdd);
        cmd.idx_clear = 1'b1;
      end
      ST_EMIT: begin
        if (free) begin
          cmd.emit_add = !stat.full;
          cmd.emit_full = stat.full;
          cmd.add_write = !stat.full;
        end
      end
      ST_TICK: begin
        cmd.tick_step = !stat.idx_end;
        cmd.idx_inc = !stat.idx_end;
      end
      ST_DISP: begin
        if (!stat.idx_end) begin
          if (!stat.hit) begin
            cmd.idx_inc = 1'b1;
          end else if (free) begin
            cmd.emit_run = 1'b1;
            cmd.disp_step = 1'b1;
            cmd.remove = stat.one_shot;
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_DEL: cmd.remove = 1'b1;
      default: cmd = '0;
    endcase
  end

  // Last beat: no later pending slot (a moved-in entry is skipped anyway).
  always_comb begin
    out_valid_next = out_valid && out_stall;
    out_last_next = out_last;
    if ((state == ST_EMIT) && free) begin
      out_valid_next = 1'b1;
      out_last_next = 1'b1;
    end else if (disp_emit) begin
      out_valid_next = 1'b1;
      out_last_next = !stat.more_hits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      out_last <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      out_last <= out_last_next;
    end
  end
endmodule

>>> hdl/periodic_task_dispatch_table_top.sv
// Add: serial divide of delay and period, then one result beat.
// Tick and dispatch: walk the occupied slots in order; dispatch stalls while
// the result register is held. Delete: removes the given slot. One item at a time.
// The output register lets a result wait while the next item is accepted.
// Reset (rst, synchronous) clears the table, task count and sets tick_length 10.
module periodic_task_dispatch_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  task_tag,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  input  logic [3:0]  slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  task_tag_res,
  output logic [3:0]  slot_out,
  output logic        last
);
  import ptd_pkg::*;

  logic [15:0] tick_length;
  ptd_cmd_t    cmd;
  ptd_stat_t   stat;
  logic [1:0]  func_q;

  assign pready = 1'b1;
  assign prdata = (paddr == RegTickLength) ? {16'd0, tick_length} : 32'd0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_length <= 16'd10;
    end else if (psel && penable && pwrite && (paddr == RegTickLength)) begin
      tick_length <= pwdata[15:0];
    end
  end

  ptd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .func_in(func), .out_valid(out_valid), .out_stall(out_stall),
    .out_last(last), .stat(stat), .cmd(cmd)
  );

  ptd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .tick_length(tick_length),
    .func_in(func), .tag_in(task_tag), .delay_in(delay_ms),
    .period_in(period_ms), .slot_in(slot), .func_q(func_q),
    .res_kind(kind), .res_tag(task_tag_res), .res_slot(slot_out)
  );

  // A beat is never produced for tick or delete.
  a_no_tick_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_run || cmd.emit_add) |-> (func_q == FuncDispatch || func_q == FuncAdd))
    else $error("result beat from tick or delete");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.add_write && cmd.remove))
    else $error("add and remove at once");

  a_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(task_tag_res)))
    else $error("stalled beat changed");
endmodule
